>>> design/sas_pkg.sv
package sas_pkg;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned KEY_W      = 12;
  localparam int unsigned CNT_W      = 13;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_BEYOND   = 3'd2,
    ST_NOT_LIVE = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    status_e          status;
    logic [KEY_W-1:0] live_count;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] addr;
    logic             val;
  } live_wr_t;

  typedef struct packed {
    logic             push;
    logic [KEY_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [KEY_W-1:0] rd_addr;
  } stk_ctl_t;

endpackage

>>> design/sas_live_bits.sv
module sas_live_bits import sas_pkg::*; (
  input  logic             clk_i,
  input  logic [KEY_W-1:0] rd_addr_i,
  input  live_wr_t         wr_i,
  output logic             rd_data_o
);

  logic live_mem [SLOT_COUNT];
  logic rd_q;

  // same-edge write is forwarded to the read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      live_mem[wr_i.addr] <= wr_i.val;
    end
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.val;
    end else begin
      rd_q <= live_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> design/sas_free_stack.sv
module sas_free_stack import sas_pkg::*; (
  input  logic             clk_i,
  input  stk_ctl_t         ctl_i,
  output logic [KEY_W-1:0] top_o
);

  logic [KEY_W-1:0] stack_mem [SLOT_COUNT];
  logic [KEY_W-1:0] top_q;

  // top of stack re-read every cycle, pushed key forwarded
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      stack_mem[ctl_i.wr_addr] <= ctl_i.wr_key;
    end
    if (ctl_i.push && (ctl_i.wr_addr == ctl_i.rd_addr)) begin
      top_q <= ctl_i.wr_key;
    end else begin
      top_q <= stack_mem[ctl_i.rd_addr];
    end
  end

  assign top_o = top_q;

endmodule

>>> design/sas_ctrl.sv
module sas_ctrl import sas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  req_t             req_i,
  input  logic             live_rd_i,
  input  logic [KEY_W-1:0] top_i,
  output live_wr_t         live_wr_o,
  output stk_ctl_t         stk_o,
  output logic             valid_o,
  output rsp_t             rsp_o
);

  logic             req_vld_q;
  req_t             req_q;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] hw_q, hw_d;
  logic [KEY_W-1:0] total_q, total_d;
  logic             valid_q;
  rsp_t             rsp_q, rsp_d;
  status_e          chk;

  always_comb begin
    if (req_q.key == '0) begin
      chk = ST_NULL;
    end else if ({1'b0, req_q.key} >= hw_q) begin
      chk = ST_BEYOND;
    end else if (!live_rd_i) begin
      chk = ST_NOT_LIVE;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    depth_d        = depth_q;
    hw_d           = hw_q;
    total_d        = total_q;
    live_wr_o      = '0;
    stk_o.push     = 1'b0;
    stk_o.wr_addr  = depth_q[KEY_W-1:0];
    stk_o.wr_key   = req_q.key;
    rsp_d.key_out  = req_q.key;
    rsp_d.status   = chk;
    if (req_vld_q) begin
      unique case (req_q.func)
        FUNC_ALLOC: begin
          if (depth_q != '0) begin
            depth_d        = depth_q - CNT_W'(1);
            rsp_d.key_out  = top_i;
            rsp_d.status   = ST_OK;
            live_wr_o      = '{en: 1'b1, addr: top_i, val: 1'b1};
            total_d        = total_q + KEY_W'(1);
          end else if (hw_q < CNT_W'(SLOT_COUNT)) begin
            hw_d           = hw_q + CNT_W'(1);
            rsp_d.key_out  = hw_q[KEY_W-1:0];
            rsp_d.status   = ST_OK;
            live_wr_o      = '{en: 1'b1, addr: hw_q[KEY_W-1:0], val: 1'b1};
            total_d        = total_q + KEY_W'(1);
          end else begin
            rsp_d.key_out  = '0;
            rsp_d.status   = ST_FULL;
          end
        end
        FUNC_FREE: begin
          if (chk == ST_OK) begin
            live_wr_o = '{en: 1'b1, addr: req_q.key, val: 1'b0};
            if (depth_q < CNT_W'(SLOT_COUNT)) begin
              stk_o.push = 1'b1;
              depth_d    = depth_q + CNT_W'(1);
            end
            if (total_q != '0) begin
              total_d = total_q - KEY_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
    rsp_d.live_count = total_d;
    stk_o.rd_addr    = KEY_W'(depth_d - CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      valid_q   <= 1'b0;
      depth_q   <= '0;
      hw_q      <= CNT_W'(1);
      total_q   <= '0;
    end else begin
      req_vld_q <= accept_i;
      valid_q   <= req_vld_q;
      depth_q   <= depth_d;
      hw_q      <= hw_d;
      total_q   <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

>>> design/slot_allocator_free_stack_top.sv
// a result beat is registered through req_vld_q and then valid_q after its request beat is taken
// throughput: one request per cycle, busy stays low after reset
// the live bit and free stack top are read at acceptance, next state forwarded
// reset clears live count, free depth and high-water mark (to one); live bits are
// not cleared by reset, keys at or above the high-water mark are never looked at
// result beats cannot be held off by the receiver
module slot_allocator_free_stack_top import sas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  logic             busy_q;
  logic             accept;
  logic             live_rd;
  logic [KEY_W-1:0] top;
  live_wr_t         live_wr;
  stk_ctl_t         stk_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  sas_live_bits u_live (
    .clk_i     (clk_i),
    .rd_addr_i (req_i.key),
    .wr_i      (live_wr),
    .rd_data_o (live_rd)
  );

  sas_free_stack u_stack (
    .clk_i (clk_i),
    .ctl_i (stk_ctl),
    .top_o (top)
  );

  sas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req_i),
    .live_rd_i (live_rd),
    .top_i     (top),
    .live_wr_o (live_wr),
    .stk_o     (stk_ctl),
    .valid_o   (valid_o),
    .rsp_o     (rsp_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(accept, 2))
    else $error("result beat does not follow request beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == ST_FULL) |-> (rsp_o.key_out == '0))
    else $error("full result carries a key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == ST_OK) |-> (rsp_o.key_out != '0))
    else $error("null key reported ok");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_ctl.push |-> (live_wr.en && !live_wr.val && live_wr.addr == stk_ctl.wr_key))
    else $error("push without clearing the live bit");

endmodule

>>> sim/tb_slot_allocator_free_stack_top.sv
`timescale 1ns / 100ps

module tb_slot_allocator_free_stack_top import sas_pkg::*;;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_OPS = 850;
  localparam int CHURN_OPS = 150;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic valid_o;
  rsp_t rsp_o;

  slot_allocator_free_stack_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  // slot table as the block should see it
  bit             live_map [SLOT_COUNT];
  bit [KEY_W-1:0] stack_mem [SLOT_COUNT];
  bit [CNT_W-1:0] stack_depth;
  bit [CNT_W-1:0] next_fresh;
  bit [KEY_W-1:0] live_num;
  bit [KEY_W-1:0] held_keys [$];

  rsp_t pending_rsp [$];
  int   err_count;
  int   idle_cycles;
  int   burst_left;
  logic got_valid;
  rsp_t got_rsp;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsp_t predict_slot_op(req_t r);
    rsp_t e;
    int   i;
    e.key_out = r.key;
    e.status = ST_OK;
    if (r.func == FUNC_ALLOC) begin
      if (stack_depth != 0) begin
        stack_depth = stack_depth - 1;
        e.key_out = stack_mem[stack_depth];
      end else if (next_fresh < SLOT_COUNT) begin
        e.key_out = next_fresh[KEY_W-1:0];
        next_fresh = next_fresh + 1;
      end else begin
        e.key_out = '0;
        e.status = ST_FULL;
      end
      if (e.status == ST_OK) begin
        live_map[e.key_out] = 1'b1;
        live_num = live_num + 1;
        held_keys.push_back(e.key_out);
      end
    end else begin
      // free and look up share the key checks; spare func code acts as look up
      if (r.key == 0) begin
        e.status = ST_NULL;
      end else if (r.key >= next_fresh) begin
        e.status = ST_BEYOND;
      end else if (!live_map[r.key]) begin
        e.status = ST_NOT_LIVE;
      end
      if (r.func == FUNC_FREE && e.status == ST_OK) begin
        live_map[r.key] = 1'b0;
        if (stack_depth < SLOT_COUNT) begin
          stack_mem[stack_depth] = r.key;
          stack_depth = stack_depth + 1;
        end
        if (live_num != 0) begin
          live_num = live_num - 1;
        end
        for (i = 0; i < held_keys.size(); i++) begin
          if (held_keys[i] == r.key) begin
            held_keys.delete(i);
            break;
          end
        end
      end
    end
    e.live_count = live_num;
    return e;
  endfunction

  function automatic int gap_cycles();
    int p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 5) begin
      burst_left = $urandom_range(16, 48);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_req(input logic [1:0] f, input logic [KEY_W-1:0] k);
    req_t r;
    int   gap;
    gap = gap_cycles();
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
      req_i = req_t'($urandom);
    end
    r.func = f;
    r.key = k;
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    pending_rsp.push_back(predict_slot_op(r));
  endtask

  task automatic send_random_op(input int alloc_weight);
    int p;
    int q;
    logic [1:0] f;
    logic [KEY_W-1:0] k;
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    if (held_keys.size() != 0 && q < 65) begin
      k = held_keys[$urandom_range(0, held_keys.size() - 1)];
    end else if (q < 80) begin
      k = KEY_W'($urandom_range(1, next_fresh));
    end else if (q < 85) begin
      k = '0;
    end else begin
      k = KEY_W'($urandom);
    end
    if (p < alloc_weight) begin
      f = FUNC_ALLOC;
      k = KEY_W'($urandom);
    end else if (p < alloc_weight + (92 - alloc_weight) / 2) begin
      f = FUNC_FREE;
    end else if (p < 92) begin
      f = FUNC_LOOKUP;
    end else begin
      f = FUNC_SPARE;
    end
    send_req(f, k);
  endtask

  task automatic test_key_checks();
    send_req(FUNC_LOOKUP, '0);
    send_req(FUNC_LOOKUP, 12'd1);
    send_req(FUNC_FREE, 12'hFFF);
    send_req(FUNC_FREE, '0);
    send_req(FUNC_SPARE, 12'd5);
  endtask

  task automatic test_alloc_free_order();
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, 12'hFFF);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, 12'd2);
    send_req(FUNC_FREE, 12'd2);
    send_req(FUNC_LOOKUP, 12'd2);
    send_req(FUNC_FREE, 12'd2);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_FREE, 12'd1);
    send_req(FUNC_FREE, 12'd3);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_SPARE, 12'd4);
    send_req(FUNC_LOOKUP, 12'd5);
  endtask

  task automatic test_random_ops();
    repeat (RANDOM_OPS) begin
      send_random_op(held_keys.size() > 48 ? 25 : 45);
    end
  endtask

  task automatic test_table_full();
    while (next_fresh < SLOT_COUNT || stack_depth != 0) begin
      send_req(FUNC_ALLOC, KEY_W'($urandom));
    end
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, 12'hFFF);
    send_req(FUNC_FREE, 12'hFFF);
    send_req(FUNC_FREE, 12'hFFF);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, 12'hFFF);
    send_req(FUNC_SPARE, 12'hFFF);
    repeat (CHURN_OPS) begin
      send_random_op(45);
    end
  endtask

  // result checker: sample at the rising edge, compare after the queue is settled
  initial begin
    forever begin
      @(posedge clk_i);
      got_valid = valid_o;
      got_rsp = rsp_o;
      if (got_valid === 1'b1) begin
        @(negedge clk_i);
        if (pending_rsp.size() == 0) begin
          err_count++;
          $display("%0t unexpected result beat key_out %0d status %0d live_count %0d",
                   $time, got_rsp.key_out, got_rsp.status, got_rsp.live_count);
        end else if (got_rsp.key_out !== pending_rsp[0].key_out ||
                     got_rsp.status !== pending_rsp[0].status ||
                     got_rsp.live_count !== pending_rsp[0].live_count) begin
          err_count++;
          $display("%0t mismatch exp key_out %0d status %0d live_count %0d",
                   $time, pending_rsp[0].key_out, pending_rsp[0].status,
                   pending_rsp[0].live_count);
          $display("%0t          got key_out %0d status %0d live_count %0d",
                   $time, got_rsp.key_out, got_rsp.status, got_rsp.live_count);
          void'(pending_rsp.pop_front());
        end else begin
          void'(pending_rsp.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("slot_allocator_free_stack_top test failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    err_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    stack_depth = '0;
    next_fresh = 1;
    live_num = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_key_checks();
    test_alloc_free_order();
    test_random_ops();
    test_table_full();

    @(negedge clk_i);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("slot_allocator_free_stack_top test passed");
    end else begin
      $display("slot_allocator_free_stack_top test failed");
    end
    $finish;
  end

endmodule
